// File: hdl/lmcm_pkg.sv
// Package with shared constants and the controller-to-datapath command type.
package lmcm_pkg;

  localparam int SIDE = 32;
  localparam int POS_W = $clog2(SIDE);
  localparam int DATA_W = 8;
  localparam int ENT_W = 3 * DATA_W;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SIDE - 1);

  typedef struct packed {
    logic             load;
    logic             wr_en;
    logic [POS_W-1:0] waddr;
    logic             rd_en;
    logic [POS_W-1:0] raddr;
    logic             shift;
    logic             emit;
    logic             en_up;
    logic             en_down;
    logic             en_left;
    logic             en_right;
    logic             last;
  } lmcm_cmd_t;

endpackage

// File: hdl/lmcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lmcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/lmcm_datapath.sv
// Datapath: line memory, neighbor window, corner test and output word register.
module lmcm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lmcm_pkg::lmcm_cmd_t               cmd_i,
  input  logic                              cfg_we_i,
  input  logic [lmcm_pkg::DATA_W-1:0]       cfg_wdata_i,
  input  logic [lmcm_pkg::DATA_W-1:0]       label_i,
  input  logic [lmcm_pkg::DATA_W-1:0]       base_value_i,
  output logic [lmcm_pkg::DATA_W-1:0]       out_value_o,
  output logic                              is_corner_o,
  output logic                              frame_last_o
);

  logic [lmcm_pkg::DATA_W-1:0] mark_q;
  logic [lmcm_pkg::DATA_W-1:0] cur_q;
  logic [lmcm_pkg::DATA_W-1:0] left_q;
  logic [lmcm_pkg::DATA_W-1:0] mid_q;
  logic [lmcm_pkg::DATA_W-1:0] up_q;
  logic [lmcm_pkg::DATA_W-1:0] base_q;
  logic [lmcm_pkg::DATA_W-1:0] out_value_q;
  logic                        is_corner_q;
  logic                        frame_last_q;
  logic [lmcm_pkg::ENT_W-1:0]  wdata;
  logic [lmcm_pkg::ENT_W-1:0]  rdata;
  logic [lmcm_pkg::DATA_W-1:0] rd_base;
  logic [lmcm_pkg::DATA_W-1:0] rd_label;
  logic [lmcm_pkg::DATA_W-1:0] rd_up;
  logic                        vert;
  logic                        horz;
  logic                        corner;

  // Each entry holds a column's base value, its label, and the label one row above.
  assign wdata = {base_value_i, label_i, mid_q};
  assign {rd_base, rd_label, rd_up} = rdata;

  lmcm_ram #(
    .WIDTH(lmcm_pkg::ENT_W),
    .DEPTH(lmcm_pkg::SIDE)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(cmd_i.waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.raddr),
    .rdata_o(rdata)
  );

  assign vert = (cmd_i.en_up && (up_q != mid_q)) || (cmd_i.en_down && (cur_q != mid_q));
  assign horz = (cmd_i.en_left && (left_q != mid_q)) ||
                (cmd_i.en_right && (rd_label != mid_q));
  assign corner = vert && horz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0;
    end else if (cfg_we_i) begin
      mark_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= label_i;
    end
    if (cmd_i.emit) begin
      out_value_q  <= corner ? mark_q : base_q;
      is_corner_q  <= corner;
      frame_last_q <= cmd_i.last;
    end
    if (cmd_i.shift) begin
      left_q <= mid_q;
      mid_q  <= rd_label;
      up_q   <= rd_up;
      base_q <= rd_base;
    end
  end

  assign out_value_o  = out_value_q;
  assign is_corner_o  = is_corner_q;
  assign frame_last_o = frame_last_q;

endmodule

// File: hdl/lmcm_ctrl.sv
// Controller: raster counters, end-of-frame flush sequencing and handshakes.
module lmcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lmcm_pkg::lmcm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROC,
    S_FREAD,
    S_FEMIT
  } state_e;

  state_e                     state_q, state_d;
  logic [lmcm_pkg::POS_W-1:0] row_q, row_d;
  logic [lmcm_pkg::POS_W-1:0] col_q, col_d;
  logic [lmcm_pkg::POS_W-1:0] flush_q, flush_d;
  logic                       out_valid_q, out_valid_d;
  logic                       slot_free;
  logic [lmcm_pkg::POS_W-1:0] next_col;
  logic [lmcm_pkg::POS_W-1:0] next_flush;
  lmcm_pkg::lmcm_cmd_t        cmd;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign next_col   = (col_q == lmcm_pkg::LAST_POS) ? '0 : col_q + 1'b1;
  assign next_flush = (flush_q == lmcm_pkg::LAST_POS) ? '0 : flush_q + 1'b1;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    flush_d = flush_q;
    case (state_q)
      S_IDLE: begin
        cmd.waddr = col_q;
        cmd.raddr = next_col;
        if (in_valid_i) begin
          cmd.load  = 1'b1;
          cmd.wr_en = 1'b1;
          cmd.rd_en = 1'b1;
          state_d   = S_PROC;
        end
      end
      S_PROC: begin
        cmd.en_up    = (row_q > lmcm_pkg::POS_W'(1));
        cmd.en_down  = 1'b1;
        cmd.en_left  = (col_q != '0);
        cmd.en_right = (col_q != lmcm_pkg::LAST_POS);
        if (slot_free) begin
          cmd.shift = 1'b1;
          cmd.emit  = (row_q != '0);
          if (col_q == lmcm_pkg::LAST_POS) begin
            col_d = '0;
            if (row_q == lmcm_pkg::LAST_POS) begin
              row_d   = '0;
              flush_d = '0;
              state_d = S_FREAD;
            end else begin
              row_d   = row_q + 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            col_d   = col_q + 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_FREAD: begin
        cmd.rd_en = 1'b1;
        cmd.raddr = next_flush;
        state_d   = S_FEMIT;
      end
      S_FEMIT: begin
        cmd.en_up    = 1'b1;
        cmd.en_left  = (flush_q != '0);
        cmd.en_right = (flush_q != lmcm_pkg::LAST_POS);
        cmd.last     = (flush_q == lmcm_pkg::LAST_POS);
        if (slot_free) begin
          cmd.shift = 1'b1;
          cmd.emit  = 1'b1;
          if (flush_q == lmcm_pkg::LAST_POS) begin
            state_d = S_IDLE;
          end else begin
            flush_d = flush_q + 1'b1;
            state_d = S_FREAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      flush_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: hdl/label_map_corner_marker_unit.sv
// Top level of the label-map corner marker: controller, datapath and checks.
//
// A square label map and its base map enter in raster order, one pixel pair per
// input word on a valid/ready channel. Each result word carries the output byte
// (the mark code at corner pixels, otherwise the base byte), a corner flag and
// a frame-last flag. The mark code is written through cfg_we_i/cfg_wdata_i.
// Each input word is stored while the line memory is read, then a pixel is
// evaluated. Results trail the inputs by one row: the word for pixel p is
// evaluated and registered after pixel p plus one row is accepted, once the
// result register is free. The first row of a frame gives no result. After
// the last pixel of the frame the block emits the whole last row, each result
// through a read state and an emit state, and takes no input during that
// flush. A result register holds each word until it is taken; while the
// receiver stalls the block may store an input word but then waits before
// evaluating it, without dropping anything. Reset clears the raster position,
// the mark code and the handshake state; the line memory needs no clearing.
module label_map_corner_marker_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lmcm_pkg::DATA_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lmcm_pkg::DATA_W-1:0] label_i,
  input  logic [lmcm_pkg::DATA_W-1:0] base_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lmcm_pkg::DATA_W-1:0] out_value_o,
  output logic                        is_corner_o,
  output logic                        frame_last_o
);

  lmcm_pkg::lmcm_cmd_t cmd;

  lmcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  lmcm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .label_i     (label_i),
    .base_value_i(base_value_i),
    .out_value_o (out_value_o),
    .is_corner_o (is_corner_o),
    .frame_last_o(frame_last_o)
  );

  // An accepted word is processed before the next one is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a word is still in process");

  // The line memory is never written and read at the same entry.
  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_en && cmd.rd_en) |-> (cmd.waddr != cmd.raddr))
    else $error("line memory read and write collide");

  // The frame's final result appears at the output right after it is evaluated.
  a_last_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last) |=> (out_valid_o && frame_last_o))
    else $error("final result of the frame not presented");

  // A new result is only produced into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule
